/* rtl/cpc_pkg.sv */
package cpc_pkg;

    // normal components always carry this many fraction bits
    localparam int NORM_BITS = 16;
    localparam int ROOT_STAGES = 32;
    localparam int QUO_BITS = NORM_BITS + 1;
    localparam int NUM_W = 32 + NORM_BITS + 1;

    // per-item values that ride along the pipeline
    typedef struct packed {
        logic               hit;
        logic               coinc;
        logic               neg_x;
        logic               neg_y;
        logic [31:0]        mag_x;
        logic [31:0]        mag_y;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic [30:0]        radius_a;
        logic [31:0]        rsum;
    } side_t;

endpackage

/* rtl/circle_pair_contact.sv */
// circle pair contact test, fully pipelined
// pipeline: 3 front stages, 32 square root stages, 18 divider stages, 2 output stages
// throughput: one pair per cycle; busy is always low and done pulses once per pair
// reset: asynchronous active low, clears only the stage valid bits
module circle_pair_contact
    import cpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic [30:0]        radius_a,
    input  logic [30:0]        radius_b,
    output logic               done,
    output logic               hit,
    output logic [31:0]        penetration,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y,
    output logic signed [31:0] contact_x,
    output logic signed [31:0] contact_y
);

    // front: deltas, exact squares, overlap compare
    logic        f_valid;
    logic [63:0] f_d2;
    side_t       f_side;

    // square root: one result bit per stage
    logic        s_valid;
    logic [31:0] s_root;
    side_t       s_side;

    // divider: both normal components, one quotient bit per stage
    logic                d_valid;
    logic [QUO_BITS-1:0] d_qx, d_qy;
    logic [31:0]         d_dist;
    side_t               d_side;

    // the pipeline never stalls, so every start beat is taken
    assign busy = 1'b0;

    cpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .radius_a  (radius_a),
        .radius_b  (radius_b),
        .out_valid (f_valid),
        .out_d2    (f_d2),
        .out_side  (f_side)
    );

    cpc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_d2     (f_d2),
        .in_side   (f_side),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    cpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_dist   (s_root),
        .in_side   (s_side),
        .out_valid (d_valid),
        .out_qx    (d_qx),
        .out_qy    (d_qy),
        .out_dist  (d_dist),
        .out_side  (d_side)
    );

    // contact point, saturation and miss / coincident selection
    cpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (d_valid),
        .in_qx       (d_qx),
        .in_qy       (d_qy),
        .in_dist     (d_dist),
        .in_side     (d_side),
        .done        (done),
        .hit         (hit),
        .penetration (penetration),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .contact_x   (contact_x),
        .contact_y   (contact_y)
    );

endmodule

/* rtl/cpc_front.sv */
module cpc_front
    import cpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic [30:0]        radius_a,
    input  logic [30:0]        radius_b,
    output logic               out_valid,
    output logic [63:0]        out_d2,
    output side_t              out_side
);

    logic [3:1] vld_reg;

    logic signed [32:0] dx, dy;
    logic [32:0] ux, uy;

    logic [32:0] ux1_reg, uy1_reg;
    logic neg_x1_reg, neg_y1_reg;
    logic signed [31:0] ax1_reg, ay1_reg;
    logic [30:0] ra1_reg;
    logic [31:0] rsum1_reg;

    logic [65:0] sx2_reg, sy2_reg;
    logic [63:0] r2_2_reg;
    logic [31:0] mx2_reg, my2_reg;
    logic neg_x2_reg, neg_y2_reg;
    logic signed [31:0] ax2_reg, ay2_reg;
    logic [30:0] ra2_reg;
    logic [31:0] rsum2_reg;

    logic [66:0] d2_sum;
    logic [63:0] d2_reg;
    side_t side_reg;

    assign dx = {b_x[31], b_x} - {a_x[31], a_x};
    assign dy = {b_y[31], b_y} - {a_y[31], a_y};
    assign ux = dx[32] ? 33'(-dx) : 33'(dx);
    assign uy = dy[32] ? 33'(-dy) : 33'(dy);
    assign d2_sum = {1'b0, sx2_reg} + {1'b0, sy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // differences and magnitudes
        ux1_reg    <= ux;
        uy1_reg    <= uy;
        neg_x1_reg <= dx[32];
        neg_y1_reg <= dy[32];
        ax1_reg    <= a_x;
        ay1_reg    <= a_y;
        ra1_reg    <= radius_a;
        rsum1_reg  <= {1'b0, radius_a} + {1'b0, radius_b};
        // squares
        sx2_reg    <= ux1_reg * ux1_reg;
        sy2_reg    <= uy1_reg * uy1_reg;
        r2_2_reg   <= rsum1_reg * rsum1_reg;
        mx2_reg    <= ux1_reg[31:0];
        my2_reg    <= uy1_reg[31:0];
        neg_x2_reg <= neg_x1_reg;
        neg_y2_reg <= neg_y1_reg;
        ax2_reg    <= ax1_reg;
        ay2_reg    <= ay1_reg;
        ra2_reg    <= ra1_reg;
        rsum2_reg  <= rsum1_reg;
        // overlap test
        d2_reg            <= d2_sum[63:0];
        side_reg.hit      <= d2_sum < {3'b000, r2_2_reg};
        side_reg.coinc    <= d2_sum == '0;
        side_reg.neg_x    <= neg_x2_reg;
        side_reg.neg_y    <= neg_y2_reg;
        side_reg.mag_x    <= mx2_reg;
        side_reg.mag_y    <= my2_reg;
        side_reg.a_x      <= ax2_reg;
        side_reg.a_y      <= ay2_reg;
        side_reg.radius_a <= ra2_reg;
        side_reg.rsum     <= rsum2_reg;
    end

    assign out_valid = vld_reg[3];
    assign out_d2    = d2_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/cpc_sqrt.sv */
module cpc_sqrt
    import cpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] in_d2,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output side_t       out_side
);

    logic        vld_reg  [0:ROOT_STAGES-1];
    logic [63:0] rad_reg  [0:ROOT_STAGES-1];
    logic [32:0] rem_reg  [0:ROOT_STAGES-1];
    logic [31:0] root_reg [0:ROOT_STAGES-1];
    side_t       side_reg [0:ROOT_STAGES-1];

    genvar g;
    generate
        for (g = 0; g < ROOT_STAGES; g++)
        begin : g_stage
            logic        v_in;
            logic [63:0] rad_in;
            logic [32:0] rem_in;
            logic [31:0] root_in;
            side_t       side_in;
            logic [34:0] rem_sh, trial;
            logic        ge;

            if (g == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign rad_in  = in_d2;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign v_in    = vld_reg[g-1];
                assign rad_in  = rad_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign side_in = side_reg[g-1];
            end

            // bring in two radicand bits, try root*4+1
            assign rem_sh = {rem_in, rad_in[63:62]};
            assign trial  = {1'b0, root_in, 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rad_reg[g]  <= {rad_in[61:0], 2'b00};
                rem_reg[g]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
                root_reg[g] <= {root_in[30:0], ge};
                side_reg[g] <= side_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_STAGES-1];
    assign out_root  = root_reg[ROOT_STAGES-1];
    assign out_side  = side_reg[ROOT_STAGES-1];

endmodule

/* rtl/cpc_div.sv */
module cpc_div
    import cpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         in_dist,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [QUO_BITS-1:0] out_qx,
    output logic [QUO_BITS-1:0] out_qy,
    output logic [31:0]         out_dist,
    output side_t               out_side
);

    // entry 0 holds the rounded numerators, then one quotient bit a stage
    logic                vld_reg  [0:QUO_BITS];
    logic [NUM_W-1:0]    rx_reg   [0:QUO_BITS];
    logic [NUM_W-1:0]    ry_reg   [0:QUO_BITS];
    logic [QUO_BITS-1:0] qx_reg   [0:QUO_BITS];
    logic [QUO_BITS-1:0] qy_reg   [0:QUO_BITS];
    logic [31:0]         dist_reg [0:QUO_BITS];
    side_t               side_reg [0:QUO_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]   <= {1'b0, in_side.mag_x, {NORM_BITS{1'b0}}}
                       + {{(NUM_W-31){1'b0}}, in_dist[31:1]};
        ry_reg[0]   <= {1'b0, in_side.mag_y, {NORM_BITS{1'b0}}}
                       + {{(NUM_W-31){1'b0}}, in_dist[31:1]};
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        dist_reg[0] <= in_dist;
        side_reg[0] <= in_side;
    end

    genvar g;
    generate
        for (g = 1; g <= QUO_BITS; g++)
        begin : g_stage
            logic [NUM_W-1:0] dsh;
            logic             gx, gy;

            assign dsh = {{(NUM_W-32){1'b0}}, dist_reg[g-1]} << (QUO_BITS - g);
            assign gx  = rx_reg[g-1] >= dsh;
            assign gy  = ry_reg[g-1] >= dsh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= vld_reg[g-1];
                end
            end

            always_ff @(posedge clk)
            begin
                rx_reg[g]   <= gx ? rx_reg[g-1] - dsh : rx_reg[g-1];
                ry_reg[g]   <= gy ? ry_reg[g-1] - dsh : ry_reg[g-1];
                qx_reg[g]   <= {qx_reg[g-1][QUO_BITS-2:0], gx};
                qy_reg[g]   <= {qy_reg[g-1][QUO_BITS-2:0], gy};
                dist_reg[g] <= dist_reg[g-1];
                side_reg[g] <= side_reg[g-1];
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_BITS];
    assign out_qx    = qx_reg[QUO_BITS];
    assign out_qy    = qy_reg[QUO_BITS];
    assign out_dist  = dist_reg[QUO_BITS];
    assign out_side  = side_reg[QUO_BITS];

endmodule

/* rtl/cpc_back.sv */
module cpc_back
    import cpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [QUO_BITS-1:0] in_qx,
    input  logic [QUO_BITS-1:0] in_qy,
    input  logic [31:0]         in_dist,
    input  side_t               in_side,
    output logic                done,
    output logic                hit,
    output logic [31:0]         penetration,
    output logic signed [17:0]  normal_x,
    output logic signed [17:0]  normal_y,
    output logic signed [31:0]  contact_x,
    output logic signed [31:0]  contact_y
);

    localparam int PW = QUO_BITS + 31;

    logic              v1_reg, done_reg;
    logic [PW-1:0]     px_reg, py_reg;
    logic [QUO_BITS-1:0] qx1_reg, qy1_reg;
    logic [31:0]       pen_reg;
    side_t             side1_reg;

    logic              hit_reg;
    logic [31:0]       pen_out_reg;
    logic [17:0]       nx_reg, ny_reg;
    logic [31:0]       cx_reg, cy_reg;

    logic [PW:0]       rx_sum, ry_sum;
    logic [PW-NORM_BITS:0] sx, sy;
    logic signed [34:0] cx_raw, cy_raw;
    logic [31:0]       cx_sat, cy_sat;
    logic [17:0]       nx, ny;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        begin
            if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111)
                r = v[31:0];
            else if (v[34])
                r = 32'h8000_0000;
            else
                r = 32'h7fff_ffff;
            return r;
        end
    endfunction

    // round half away from zero on the magnitude, then apply the sign
    assign rx_sum = {1'b0, px_reg} + (PW+1)'(1 << (NORM_BITS - 1));
    assign ry_sum = {1'b0, py_reg} + (PW+1)'(1 << (NORM_BITS - 1));
    assign sx = rx_sum[PW:NORM_BITS];
    assign sy = ry_sum[PW:NORM_BITS];
    assign cx_raw = side1_reg.neg_x
                    ? 35'(side1_reg.a_x) - 35'(signed'({1'b0, sx}))
                    : 35'(side1_reg.a_x) + 35'(signed'({1'b0, sx}));
    assign cy_raw = side1_reg.neg_y
                    ? 35'(side1_reg.a_y) - 35'(signed'({1'b0, sy}))
                    : 35'(side1_reg.a_y) + 35'(signed'({1'b0, sy}));
    assign cx_sat = sat32(cx_raw);
    assign cy_sat = sat32(cy_raw);
    assign nx = side1_reg.neg_x ? 18'(-{1'b0, qx1_reg}) : {1'b0, qx1_reg};
    assign ny = side1_reg.neg_y ? 18'(-{1'b0, qy1_reg}) : {1'b0, qy1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= in_qx * in_side.radius_a;
        py_reg    <= in_qy * in_side.radius_a;
        qx1_reg   <= in_qx;
        qy1_reg   <= in_qy;
        pen_reg   <= in_side.rsum - in_dist;
        side1_reg <= in_side;

        if (!side1_reg.hit)
        begin
            hit_reg     <= 1'b0;
            pen_out_reg <= '0;
            nx_reg      <= '0;
            ny_reg      <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
        end
        else if (side1_reg.coinc)
        begin
            hit_reg     <= 1'b1;
            pen_out_reg <= {1'b0, side1_reg.radius_a};
            nx_reg      <= 18'(1 << NORM_BITS);
            ny_reg      <= '0;
            cx_reg      <= side1_reg.a_x;
            cy_reg      <= side1_reg.a_y;
        end
        else
        begin
            hit_reg     <= 1'b1;
            pen_out_reg <= pen_reg;
            nx_reg      <= nx;
            ny_reg      <= ny;
            cx_reg      <= cx_sat;
            cy_reg      <= cy_sat;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign penetration = pen_out_reg;
    assign normal_x    = signed'(nx_reg);
    assign normal_y    = signed'(ny_reg);
    assign contact_x   = signed'(cx_reg);
    assign contact_y   = signed'(cy_reg);

endmodule
